### design/stst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stst_pkg: shared types and codes of the section timing statistics table
// Command codes, field widths and the request/response beat structures.
// ----------------------------------------------------------------------------
package stst_pkg;

   localparam int CMD_BITS  = 2;
   localparam int ID_BITS   = 6;
   localparam int ID_SPAN   = 2 ** ID_BITS;
   localparam int NOW_BITS  = 32;
   localparam int CNT_BITS  = 32;
   localparam int TOT_BITS  = 48;
   localparam int FLD_BITS  = 32;

   localparam logic [CMD_BITS-1:0] CMD_START = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_STOP  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic [ID_BITS-1:0]  timer_id;
      logic [NOW_BITS-1:0] now;
   } req_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] run_count;
      logic [TOT_BITS-1:0] total_time;
      logic [FLD_BITS-1:0] max_time;
      logic [CNT_BITS-1:0] max_call;
      logic [FLD_BITS-1:0] second_max_time;
      logic [FLD_BITS-1:0] min_time;
      logic                is_running;
      logic                status;
   } rsp_type;

endpackage
`default_nettype wire

### design/stst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stst_ram: one-write, one-read table memory with registered read
// Write-first: a read of the address written in the same cycle returns the
// new data.
// ----------------------------------------------------------------------------
module stst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // pass write data through on an address match
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/section_timing_stats_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// section_timing_stats_table_core: table of profiling timers
// Start/stop timing per timer id with run count, saturating total, max with
// its run number, second max and min; clear-all and read of one entry.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_item and raise start; a beat is taken at each
//    rising edge with start high and busy low. busy is high only while reset
//    is applied and the cycle after, so one beat can be taken every cycle.
//  - Response channel: every request yields exactly one beat on rsp_item,
//    marked by rsp_strobe for one cycle. The receiver cannot stall it.
//  - Response path: the request edge loads the stage-1 registers and the
//    registered reads; the read-modify-write edge loads the response
//    register and strobe. Throughput is one request per cycle while busy is low.
//  - Each request reads the entry at its edge from the table memories
//    (registered read) and writes it back at the read-modify-write edge; a
//    back-to-back request to the same id reads new data from the write-first RAM.
//  - Reset clears the running flags, the statistics valid bits and the
//    pipeline. The statistics memory is not swept: an entry whose valid bit
//    is clear reads as zero. Clear-all drops every valid bit at once.
//  - Ids at or above NUM_TIMERS report zero statistics; only clear acts.
// ----------------------------------------------------------------------------
module section_timing_stats_table_core #(
   parameter int NUM_TIMERS = 64,
   parameter int TIME_BITS  = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire stst_pkg::req_type req_item,
   output logic                   busy,
   output logic                   rsp_strobe,
   output stst_pkg::rsp_type      rsp_item
);

   // only ids that fit the id field can ever be addressed
   localparam int DEPTH = (NUM_TIMERS < stst_pkg::ID_SPAN) ? NUM_TIMERS : stst_pkg::ID_SPAN;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIM_W = stst_pkg::ID_BITS + 1;
   localparam logic [LIM_W-1:0] ID_LIMIT = LIM_W'(DEPTH);
   localparam int SUM_W = stst_pkg::TOT_BITS + 1;

   typedef struct packed {
      logic [stst_pkg::CNT_BITS-1:0] count;
      logic [stst_pkg::TOT_BITS-1:0] total;
      logic [TIME_BITS-1:0]          max_t;
      logic [stst_pkg::CNT_BITS-1:0] max_call;
      logic [TIME_BITS-1:0]          second_t;
      logic [TIME_BITS-1:0]          min_t;
   } stats_type;

   localparam int STATS_W = $bits(stats_type);

   // report a duration in a 32-bit field, dropping upper bits
   function automatic logic [stst_pkg::FLD_BITS-1:0] to_field(input logic [TIME_BITS-1:0] x);
      logic [TIME_BITS+stst_pkg::FLD_BITS-1:0] ext;
      ext = {{stst_pkg::FLD_BITS{1'b0}}, x};
      return ext[stst_pkg::FLD_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------- stage 0
   logic                           accept;
   logic [IDX_W-1:0]               req_idx;
   logic                           req_in_range;
   logic [TIME_BITS+stst_pkg::NOW_BITS-1:0] now_ext;
   logic [TIME_BITS-1:0]           req_now;

   logic                           busy_ff;
   logic                           s1_valid_ff;
   logic [stst_pkg::CMD_BITS-1:0]  s1_cmd_ff;
   logic [IDX_W-1:0]               s1_idx_ff;
   logic                           s1_in_range_ff;
   logic [TIME_BITS-1:0]           s1_now_ff;

   assign busy         = busy_ff;
   assign accept       = start && !busy_ff;
   assign req_idx      = req_item.timer_id[IDX_W-1:0];
   assign req_in_range = ({1'b0, req_item.timer_id} < ID_LIMIT);
   assign now_ext      = {{TIME_BITS{1'b0}}, req_item.now};
   assign req_now      = now_ext[TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= accept;
      end
      // hold the beat for the read-modify-write cycle
      s1_cmd_ff      <= req_item.cmd;
      s1_idx_ff      <= req_idx;
      s1_in_range_ff <= req_in_range;
      s1_now_ff      <= req_now;
   end

   // ---------------------------------------------------------------- memories
   logic                 stamp_we;
   logic [TIME_BITS-1:0] stamp_rd;
   logic                 stats_we;
   stats_type            stats_new;
   logic [STATS_W-1:0]   stats_rd_bits;
   stats_type            stats_rd;

   stst_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_now_ff),
      .rd_addr (req_idx),
      .rd_data (stamp_rd)
   );

   stst_ram #(
      .WIDTH (STATS_W),
      .DEPTH (DEPTH)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (stats_we),
      .wr_addr (s1_idx_ff),
      .wr_data (stats_new),
      .rd_addr (req_idx),
      .rd_data (stats_rd_bits)
   );

   assign stats_rd = stats_rd_bits;

   // ---------------------------------------------------------------- stage 1
   logic [DEPTH-1:0] run_ff;
   logic [DEPTH-1:0] vld_ff;

   logic                          cur_run;
   logic                          cur_vld;
   stats_type                     cur_stats;
   logic [TIME_BITS-1:0]          dur;
   logic [SUM_W-1:0]              sum;
   logic [stst_pkg::CNT_BITS-1:0] cnt_next;
   logic                          run_set;
   logic                          run_clr;
   logic                          clear_all;
   logic                          vld_after;
   logic                          run_after;
   logic                          status;
   stats_type                     stats_out;
   stst_pkg::rsp_type             rsp_in;
   stst_pkg::rsp_type             rsp_item_ff;
   logic                          rsp_strobe_ff;

   assign cur_run = run_ff[s1_idx_ff];
   assign cur_vld = vld_ff[s1_idx_ff];
   // an entry without its valid bit holds zero statistics
   assign cur_stats = cur_vld ? stats_rd : '0;
   assign dur       = s1_now_ff - stamp_rd;
   assign sum       = {1'b0, cur_stats.total} + SUM_W'(dur);
   assign cnt_next  = (&cur_stats.count) ? cur_stats.count : cur_stats.count + 1'b1;

   always_comb begin
      stats_new = cur_stats;
      stats_new.count = cnt_next;
      stats_new.total = sum[SUM_W-1] ? {stst_pkg::TOT_BITS{1'b1}}
                                     : sum[stst_pkg::TOT_BITS-1:0];
      // max, else second max, else min (zero min means unset)
      if (dur > cur_stats.max_t) begin
         stats_new.second_t = cur_stats.max_t;
         stats_new.max_t    = dur;
         stats_new.max_call = cnt_next;
      end else if (dur > cur_stats.second_t) begin
         stats_new.second_t = dur;
      end else if ((dur < cur_stats.min_t) || (cur_stats.min_t == '0)) begin
         stats_new.min_t = dur;
      end
   end

   always_comb begin
      stamp_we  = 1'b0;
      stats_we  = 1'b0;
      run_set   = 1'b0;
      run_clr   = 1'b0;
      clear_all = 1'b0;
      status    = 1'b0;
      vld_after = cur_vld;
      run_after = cur_run;
      stats_out = cur_stats;
      unique case (s1_cmd_ff)
         stst_pkg::CMD_START: begin
            if (s1_in_range_ff && !cur_run) begin
               stamp_we  = s1_valid_ff;
               run_set   = s1_valid_ff;
               run_after = 1'b1;
            end else begin
               status = 1'b1;
            end
         end
         stst_pkg::CMD_STOP: begin
            if (s1_in_range_ff && cur_run) begin
               stats_we  = s1_valid_ff;
               run_clr   = s1_valid_ff;
               run_after = 1'b0;
               vld_after = 1'b1;
               stats_out = stats_new;
            end else begin
               status = 1'b1;
            end
         end
         stst_pkg::CMD_CLEAR: begin
            clear_all = s1_valid_ff;
            vld_after = 1'b0;
         end
         stst_pkg::CMD_READ: begin
         end
         default: begin
         end
      endcase

      if (!(s1_in_range_ff && vld_after)) begin
         stats_out = '0;
      end

      rsp_in.run_count       = stats_out.count;
      rsp_in.total_time      = stats_out.total;
      rsp_in.max_time        = to_field(stats_out.max_t);
      rsp_in.max_call        = stats_out.max_call;
      rsp_in.second_max_time = to_field(stats_out.second_t);
      rsp_in.min_time        = to_field(stats_out.min_t);
      rsp_in.is_running      = s1_in_range_ff && run_after;
      rsp_in.status          = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= '0;
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (run_set) begin
            run_ff[s1_idx_ff] <= 1'b1;
         end
         if (run_clr) begin
            run_ff[s1_idx_ff] <= 1'b0;
         end
         // drop every entry's statistics at once
         if (clear_all) begin
            vld_ff <= '0;
         end else if (stats_we) begin
            vld_ff[s1_idx_ff] <= 1'b1;
         end
         rsp_strobe_ff <= s1_valid_ff;
      end
      rsp_item_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire
